@@ sv/calh_pkg.sv @@
// Shared types, constants and calendar helpers for the calendar hour stepper.
package calh_pkg;

  localparam int DVD_W = 16;   // divider dividend / quotient width
  localparam int DSR_W = 8;    // divider divisor / remainder width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_START_DAY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MONTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_YEAR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOURS_PER_DAY = 2'd3;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Year is kept as century and year-in-century, both 0..99.
  localparam logic [6:0] CENT_MAX = 7'd99;
  localparam logic [7:0] YEAR_RADIX = 8'd100;
  // ceil(2^19 / 100): (y * YEAR_RECIP) >> 19 equals y / 100 for any 14-bit y
  localparam logic [12:0] YEAR_RECIP = 13'd5243;

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] hour_delta;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic [7:0]  hour_out;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DSR_W-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       back;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] cent;
    logic [6:0] yic;
  } date_cmd_t;

  // Days in a month; months outside 1..12 count as 30 days.
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
    logic [4:0] md;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: md = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    md = 5'd30;
      MONTH_FEB:                                  md = leap ? 5'd29 : 5'd28;
      default:                                    md = 5'd30;
    endcase
    return md;
  endfunction

endpackage

@@ sv/calendar_hour_stepper.sv @@
// Calendar hour stepper top level: sequencer, config registers and result register.
// Sequence: a load goes through FIX to DONE; an advance by zero goes straight to DONE;
//   any other advance goes DIV, FIX, then WALK one day per cycle if days remain, then DONE.
// Requests: one at a time; in_ready returns only once the result has gone to the output
//   register, so the divider and the date walk set the request rate.
// Reset (rst, synchronous): date 1/1/2000, hour 0, start registers 1/1/2000, 24 hours per day.
module calendar_hour_stepper (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  calh_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output calh_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [calh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [calh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a request
  localparam logic [2:0] ST_DIV  = 3'd1;  // divider running
  localparam logic [2:0] ST_FIX  = 3'd2;  // load the start date, or turn quotient into days
  localparam logic [2:0] ST_WALK = 3'd3;  // step the date one day per cycle
  localparam logic [2:0] ST_DONE = 3'd4;  // hand the result to the output register

  logic [2:0]  state;

  // Configuration registers
  logic [4:0]  start_day;
  logic [3:0]  start_month;
  logic [13:0] start_year;
  logic [7:0]  day_hours;

  logic [7:0]  hour;
  logic        is_load;
  logic        neg;
  logic [15:0] days;
  logic        back;

  logic        in_fire;
  logic        out_free;
  logic [7:0]  hpd_eff;
  logic signed [16:0] total;
  logic [16:0] total_mag;

  calh_pkg::div_req_t  div_req;
  calh_pkg::div_res_t  div_res;
  calh_pkg::date_cmd_t date_cmd;

  logic [4:0]  date_day;
  logic [3:0]  date_month;
  logic [13:0] date_year;

  // Start year split into centuries and year-in-century
  logic [26:0] yr_prod;
  logic [7:0]  yr_quot;
  logic [13:0] yr_hund;
  logic [13:0] yr_rem;

  // FIX-state values
  logic [7:0]  q_cent;
  logic [15:0] fix_days;
  logic [7:0]  fix_hour;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Zero hours per day behaves as one hour per day
  assign hpd_eff   = (day_hours == 8'd0) ? 8'd1 : day_hours;
  assign total     = $signed({9'b0, hour}) + 17'(in_data.hour_delta);
  assign total_mag = total[16] ? (17'd0 - total) : total;

  // Divider launch: only a nonzero advance divides the hour sum by the day length
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = total_mag[calh_pkg::DVD_W-1:0];
    div_req.divisor  = hpd_eff;
    if (in_fire && (in_data.opcode == calh_pkg::OP_ADVANCE) &&
        (in_data.hour_delta != 16'sd0)) begin
      div_req.start = 1'b1;
    end
  end

  calh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // Split the start year by 100 with a reciprocal multiply; the quotient stays below 164
  assign yr_prod = 27'(start_year) * 27'(calh_pkg::YEAR_RECIP);
  assign yr_quot = yr_prod[26:19];
  assign yr_hund = {yr_quot, 6'b0} + {1'b0, yr_quot, 5'b0} + {4'b0, yr_quot, 2'b0};
  assign yr_rem  = start_year - yr_hund;

  // Century wrap; floor division fixup: a negative sum with a remainder borrows one more day
  always_comb begin
    q_cent = yr_quot;
    if (q_cent >= calh_pkg::YEAR_RADIX) begin
      q_cent = q_cent - calh_pkg::YEAR_RADIX;   // drop the ten-thousands
    end
    if (neg && (div_res.rem != 8'd0)) begin
      fix_days = div_res.quot + 16'd1;
      fix_hour = hpd_eff - div_res.rem;
    end else begin
      fix_days = div_res.quot;
      fix_hour = div_res.rem;
    end
  end

  always_comb begin
    date_cmd.load  = (state == ST_FIX) && is_load;
    date_cmd.step  = (state == ST_WALK);
    date_cmd.back  = back;
    date_cmd.day   = start_day;
    date_cmd.month = start_month;
    date_cmd.cent  = q_cent[6:0];
    date_cmd.yic   = yr_rem[6:0];
  end

  calh_date u_date (
    .clk   (clk),
    .rst   (rst),
    .cmd   (date_cmd),
    .day   (date_day),
    .month (date_month),
    .year  (date_year)
  );

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_day   <= 5'd1;
      start_month <= calh_pkg::MONTH_JAN;
      start_year  <= 14'd2000;
      day_hours   <= 8'd24;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        calh_pkg::REG_START_DAY:     start_day   <= cfg_data[4:0];
        calh_pkg::REG_START_MONTH:   start_month <= cfg_data[3:0];
        calh_pkg::REG_START_YEAR:    start_year  <= cfg_data;
        calh_pkg::REG_HOURS_PER_DAY: day_hours   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hour      <= 8'd0;
      out_valid <= 1'b0;
      is_load   <= 1'b0;
      neg       <= 1'b0;
      back      <= 1'b0;
      days      <= '0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            is_load <= (in_data.opcode == calh_pkg::OP_LOAD);
            neg     <= total[16];
            // load goes straight to the date update; advance by zero leaves everything as it is
            if (in_data.opcode == calh_pkg::OP_LOAD) begin
              state <= ST_FIX;
            end else if (div_req.start) begin
              state <= ST_DIV;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          if (is_load) begin
            hour  <= 8'd0;
            state <= ST_DONE;
          end else begin
            hour  <= fix_hour;
            days  <= fix_days;
            back  <= neg;
            state <= (fix_days == 16'd0) ? ST_DONE : ST_WALK;
          end
        end
        ST_WALK: begin
          days <= days - 16'd1;
          if (days == 16'd1) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register: load on completion, hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data.day_out   <= date_day;
      out_data.month_out <= date_month;
      out_data.year_out  <= date_year;
      out_data.hour_out  <= hour;
    end
  end

endmodule

@@ sv/calh_div.sv @@
// Restoring divider, one quotient bit per cycle.
module calh_div (
  input  logic              clk,
  input  logic              rst,
  input  calh_pkg::div_req_t req,
  output calh_pkg::div_res_t res
);

  localparam logic [4:0] DIV_STEPS = 5'(calh_pkg::DVD_W);

  logic [4:0]                   cnt;
  logic                         done;
  logic [calh_pkg::DVD_W-1:0]   dvd;
  logic [calh_pkg::DSR_W-1:0]   rem;
  logic [calh_pkg::DSR_W-1:0]   dsr;
  logic [calh_pkg::DSR_W:0]     shifted;
  logic [calh_pkg::DSR_W:0]     diff;
  logic                         ge;
  logic [calh_pkg::DSR_W-1:0]   rem_next;

  always_comb begin
    shifted  = {rem, dvd[calh_pkg::DVD_W-1]};
    diff     = shifted - {1'b0, dsr};
    ge       = (shifted >= {1'b0, dsr});
    rem_next = ge ? diff[calh_pkg::DSR_W-1:0] : shifted[calh_pkg::DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= DIV_STEPS;
      end else if (cnt != '0) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[calh_pkg::DVD_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign res.done = done;
  assign res.quot = dvd;
  assign res.rem  = rem;

endmodule

@@ sv/calh_date.sv @@
// Date register with a one-day forward/backward stepper.
module calh_date (
  input  logic                clk,
  input  logic                rst,
  input  calh_pkg::date_cmd_t cmd,
  output logic [4:0]          day,
  output logic [3:0]          month,
  output logic [13:0]         year
);

  logic [6:0] cent;
  logic [6:0] yic;
  logic       leap;
  logic [4:0] md;
  logic [5:0] nd;
  logic [4:0] mn;
  logic [4:0] day_next;
  logic [3:0] month_next;
  logic [6:0] cent_next;
  logic [6:0] yic_next;
  logic [3:0] prev_month;

  always_comb begin
    // year % 4 follows the year-in-century since 100 is a multiple of 4
    leap = ((yic[1:0] == 2'd0) && (yic != 7'd0)) || ((yic == 7'd0) && (cent[1:0] == 2'd0));
    md   = calh_pkg::month_days(leap, month);
    nd   = {1'b0, day} + 6'd1;
    mn   = {1'b0, month} + 5'd1;
    prev_month = month - 4'd1;

    day_next   = day;
    month_next = month;
    cent_next  = cent;
    yic_next   = yic;

    if (!cmd.back) begin
      if (nd > {1'b0, md}) begin
        day_next = 5'd1;
        if (mn > {1'b0, calh_pkg::MONTH_DEC}) begin
          month_next = calh_pkg::MONTH_JAN;
          if (yic == calh_pkg::CENT_MAX) begin
            yic_next  = 7'd0;
            cent_next = (cent == calh_pkg::CENT_MAX) ? 7'd0 : cent + 7'd1;
          end else begin
            yic_next = yic + 7'd1;
          end
        end else begin
          month_next = mn[3:0];
        end
      end else begin
        day_next = nd[4:0];
      end
    end else begin
      if (day <= 5'd1) begin
        if (month <= calh_pkg::MONTH_JAN) begin
          month_next = calh_pkg::MONTH_DEC;
          day_next   = calh_pkg::month_days(leap, calh_pkg::MONTH_DEC);
          if (yic == 7'd0) begin
            yic_next  = calh_pkg::CENT_MAX;
            cent_next = (cent == 7'd0) ? calh_pkg::CENT_MAX : cent - 7'd1;
          end else begin
            yic_next = yic - 7'd1;
          end
        end else begin
          // only March steps back into February, so the year's leap flag holds
          month_next = prev_month;
          day_next   = calh_pkg::month_days(leap, prev_month);
        end
      end else begin
        day_next = day - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= 5'd1;
      month <= calh_pkg::MONTH_JAN;
      cent  <= 7'd20;
      yic   <= 7'd0;
    end else if (cmd.load) begin
      day   <= cmd.day;
      month <= cmd.month;
      cent  <= cmd.cent;
      yic   <= cmd.yic;
    end else if (cmd.step) begin
      day   <= day_next;
      month <= month_next;
      cent  <= cent_next;
      yic   <= yic_next;
    end
  end

  // cent * 100 + yic, as shifts and adds
  assign year = ({1'b0, cent, 6'b0} + {2'b0, cent, 5'b0}) + ({5'b0, cent, 2'b0} + {7'b0, yic});

endmodule

@@ sv/calh_checker.sv @@
// Port-level checker for the calendar hour stepper, bound to the top level.
module calh_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input calh_pkg::out_item_t             out_data
);

  // Result holds while the consumer stalls
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Result goes away only when taken
  assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without being taken");

  // One request at a time: busy right after accepting
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Year always wraps below ten thousand
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.year_out <= 14'd9999)
    else $error("year out of range");

endmodule

bind calendar_hour_stepper calh_checker u_calh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
